// ===== hw/rtl/vftbp_pkg.sv =====
package vftbp_pkg;

    // Field widths.
    localparam int NOW_W     = 48;
    localparam int BYTES_W   = 24;
    localparam int TOK_W     = 32;
    localparam int KBPS_W    = 16;

    // Widths of the refill datapath.
    localparam int ELAPSED_W = 10;   // 0..1000 ms
    localparam int Q_W       = 13;   // whole bytes per ms, up to 8191
    localparam int R_W       = 10;   // bytes per second left over, below 1000
    localparam int BASE_W    = 23;   // bitrate_kbps * 125
    localparam int BUCKET_W  = 24;   // up to 65535 * 250
    localparam int PQ_W      = Q_W + ELAPSED_W;
    localparam int PR_W      = 20;   // below 1000 * 1000
    localparam int REFILL_W  = 24;
    localparam int SUM_W     = TOK_W + 2;

    // Pacing constants.
    localparam logic [TOK_W-1:0]     DEBT_LIMIT_BYTES = 32'd2097152;
    localparam logic [ELAPSED_W-1:0] MAX_ELAPSED_MS   = 10'd1000;
    localparam logic [NOW_W-1:0]     ADAPT_GAP_MS     = 48'd6000;
    localparam logic [BUCKET_W-1:0]  BUCKET_FLOOR     = 24'd524288;

    // Below this bitrate the 64 KiB/s floor applies: 65536 = 65 * 1000 + 536.
    localparam logic [KBPS_W-1:0]    RATE_FLOOR_KBPS  = 16'd525;
    localparam logic [Q_W-1:0]       RATE_FLOOR_Q     = 13'd65;
    localparam logic [R_W-1:0]       RATE_FLOOR_R     = 10'd536;
    // From this bitrate on, twice the rate exceeds the 512 KiB bucket floor.
    localparam logic [KBPS_W-1:0]    BUCKET_MIN_KBPS  = 16'd2098;

    // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for every x below 2^20.
    localparam int                   RECIP_W          = 21;
    localparam int                   RECIP_SHIFT      = 30;
    localparam logic [RECIP_W-1:0]   RECIP_1000       = 21'd1073742;

    // Register map, indexed by paddr[2].
    localparam logic REG_PACING_ENABLED = 1'b0;
    localparam logic REG_BITRATE_KBPS   = 1'b1;

    localparam logic [KBPS_W-1:0]   BITRATE_RESET = 16'd3500;
    localparam logic [BASE_W-1:0]   BASE_RESET    = 23'd437500;
    localparam logic [Q_W-1:0]      Q_RESET       = 13'd437;
    localparam logic [R_W-1:0]      R_RESET       = 10'd500;
    localparam logic [BUCKET_W-1:0] BUCKET_RESET  = 24'd875000;

    // Saturate a widened sum to the 32-bit signed range.
    function automatic logic signed [TOK_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(33'sh0_7FFF_FFFF);
        lo = -SUM_W'(33'sh0_8000_0000);
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return v[TOK_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/video_frame_token_bucket_pacer_unit.sv =====
// An accepted request moves through stages 1 to 4 and then the result register.
// Throughput: one frame request per cycle while out_ready keeps results moving; the
// token-balance update loops in the last stage on a refill from the three stages before it.
// Reset (rst_n low, asynchronous): pacing off, bitrate 3500 kbit/s, an empty and unprimed
// bucket, both timestamps zero, and no request held in any stage.
module video_frame_token_bucket_pacer_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [vftbp_pkg::NOW_W-1:0]           now_ms,
    input  logic [vftbp_pkg::BYTES_W-1:0]         frame_bytes,
    input  logic                                  is_keyframe,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  forward,
    output logic                                  adapt_request,
    output logic signed [vftbp_pkg::TOK_W-1:0]    token_level
);

    // Fields that ride along with every request through the pipeline.
    typedef struct packed {
        logic [vftbp_pkg::NOW_W-1:0]   now;
        logic [vftbp_pkg::BYTES_W-1:0] bytes;
        logic                          key;
        logic                          first;
        logic                          pacing;
    } item_t;

    // Configuration registers and the values derived from the bitrate.
    logic                                 pacing_reg;
    logic [vftbp_pkg::KBPS_W-1:0]         bitrate_reg;
    logic [vftbp_pkg::BASE_W-1:0]         base_reg;
    logic [vftbp_pkg::Q_W-1:0]            rate_q_reg;
    logic [vftbp_pkg::R_W-1:0]            rate_r_reg;
    logic [vftbp_pkg::BUCKET_W-1:0]       bucket_reg;

    // Refill timing is tracked at the input, since it does not depend on the balance.
    logic                                 primed_reg;
    logic [vftbp_pkg::NOW_W-1:0]          last_refill_reg;

    // Pipeline stages.
    logic                                 s1_valid_reg;
    item_t                                s1_item_reg;
    logic [vftbp_pkg::NOW_W-1:0]          s1_prev_reg;
    logic                                 s2_valid_reg;
    item_t                                s2_item_reg;
    logic [vftbp_pkg::ELAPSED_W-1:0]      s2_elapsed_reg;
    logic                                 s3_valid_reg;
    item_t                                s3_item_reg;
    logic [vftbp_pkg::PQ_W-1:0]           s3_pq_reg;
    logic [vftbp_pkg::PR_W-1:0]           s3_pr_reg;
    logic                                 s4_valid_reg;
    item_t                                s4_item_reg;
    logic [vftbp_pkg::REFILL_W-1:0]       s4_refill_reg;

    // Balance state and the result register.
    logic signed [vftbp_pkg::TOK_W-1:0]   tok_reg;
    logic signed [vftbp_pkg::TOK_W-1:0]   tok_next;
    logic [vftbp_pkg::NOW_W-1:0]          last_adapt_reg;
    logic [vftbp_pkg::NOW_W-1:0]          last_adapt_next;
    logic                                 out_valid_reg;
    logic                                 forward_reg;
    logic                                 adapt_reg;
    logic                                 adapt_next;
    logic                                 forward_next;
    logic signed [vftbp_pkg::TOK_W-1:0]   token_level_reg;

    logic                                 cfg_write;
    logic                                 in_fire;
    logic                                 out_free;
    logic                                 loop_fire;
    logic                                 s4_free;
    logic                                 s3_free;
    logic                                 s2_free;

    logic [vftbp_pkg::BASE_W-1:0]         base_calc;
    logic [vftbp_pkg::Q_W-1:0]            q_calc;
    logic [vftbp_pkg::R_W-1:0]            r_calc;
    logic [vftbp_pkg::BUCKET_W-1:0]       bucket_calc;

    logic [vftbp_pkg::NOW_W:0]            elapsed_diff;
    logic [vftbp_pkg::ELAPSED_W-1:0]      elapsed_calc;
    logic [vftbp_pkg::PR_W+vftbp_pkg::RECIP_W-1:0] frac_prod;
    logic [vftbp_pkg::REFILL_W-1:0]       refill_calc;

    logic signed [vftbp_pkg::SUM_W-1:0]   fill_sum;
    logic signed [vftbp_pkg::SUM_W-1:0]   fill_capped;
    logic signed [vftbp_pkg::SUM_W-1:0]   spend_sum;
    logic signed [vftbp_pkg::TOK_W-1:0]   tok_filled;
    logic signed [vftbp_pkg::TOK_W-1:0]   debt_floor;
    logic                                 drop;
    logic [vftbp_pkg::NOW_W:0]            adapt_diff;
    logic                                 adapt_due;

    // ------------------------------------------------------------------
    // Configuration port. Writes land in the access phase; reads are
    // answered from the live registers.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            vftbp_pkg::REG_PACING_ENABLED: prdata = {31'd0, pacing_reg};
            vftbp_pkg::REG_BITRATE_KBPS:   prdata = {16'd0, bitrate_reg};
            default:                       prdata = '0;
        endcase
    end

    // The rate is bitrate_kbps * 125 bytes per second, floored at 64 KiB/s.
    // Split it into whole bytes per millisecond (q) and a remainder per second (r):
    // kbps * 125 = (kbps / 8) * 1000 + (kbps mod 8) * 125, so no divider is needed.
    always_comb
    begin
        base_calc = vftbp_pkg::BASE_W'({7'd0, bitrate_reg} * 23'd125);
        if (bitrate_reg < vftbp_pkg::RATE_FLOOR_KBPS)
        begin
            q_calc = vftbp_pkg::RATE_FLOOR_Q;
            r_calc = vftbp_pkg::RATE_FLOOR_R;
        end
        else
        begin
            q_calc = bitrate_reg[vftbp_pkg::KBPS_W-1:3];
            r_calc = vftbp_pkg::R_W'({7'd0, bitrate_reg[2:0]} * 10'd125);
        end
        // The bucket is twice the rate, never below 512 KiB.
        if (bitrate_reg < vftbp_pkg::BUCKET_MIN_KBPS)
        begin
            bucket_calc = vftbp_pkg::BUCKET_FLOOR;
        end
        else
        begin
            bucket_calc = vftbp_pkg::BUCKET_W'({8'd0, bitrate_reg} * 24'd250);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pacing_reg  <= 1'b0;
            bitrate_reg <= vftbp_pkg::BITRATE_RESET;
            base_reg    <= vftbp_pkg::BASE_RESET;
            rate_q_reg  <= vftbp_pkg::Q_RESET;
            rate_r_reg  <= vftbp_pkg::R_RESET;
            bucket_reg  <= vftbp_pkg::BUCKET_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[2])
                    vftbp_pkg::REG_PACING_ENABLED: pacing_reg  <= pwdata[0];
                    vftbp_pkg::REG_BITRATE_KBPS:   bitrate_reg <= pwdata[15:0];
                    default:                       pacing_reg  <= pacing_reg;
                endcase
            end
            // The derived values are registered from the bitrate and settle before any
            // request accepted after the write reaches them.
            base_reg   <= base_calc;
            rate_q_reg <= q_calc;
            rate_r_reg <= r_calc;
            bucket_reg <= bucket_calc;
        end
    end

    // ------------------------------------------------------------------
    // Elastic pipeline control. Each stage takes a new request whenever it
    // is empty or its content moves on, so bubbles close up while the
    // result register waits on the consumer.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || out_ready;
    assign loop_fire = s4_valid_reg && out_free;
    assign s4_free   = !s4_valid_reg || out_free;
    assign s3_free   = !s3_valid_reg || s4_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign in_fire   = in_valid && in_ready;

    // Stage 1: capture the request together with the refill time it is measured
    // against. The first paced request primes the bucket and starts the clock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            primed_reg      <= 1'b0;
            last_refill_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (in_fire && pacing_reg)
            begin
                primed_reg      <= 1'b1;
                last_refill_reg <= now_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.now    <= now_ms;
            s1_item_reg.bytes  <= frame_bytes;
            s1_item_reg.key    <= is_keyframe;
            s1_item_reg.first  <= pacing_reg && !primed_reg;
            s1_item_reg.pacing <= pacing_reg;
            s1_prev_reg        <= last_refill_reg;
        end
    end

    // Stage 2: elapsed time as a signed difference, clamped to 0..1000 ms.
    always_comb
    begin
        elapsed_diff = {1'b0, s1_item_reg.now} - {1'b0, s1_prev_reg};
        if (elapsed_diff[vftbp_pkg::NOW_W])
        begin
            elapsed_calc = '0;
        end
        else if (elapsed_diff[vftbp_pkg::NOW_W-1:0] >
                 {38'd0, vftbp_pkg::MAX_ELAPSED_MS})
        begin
            elapsed_calc = vftbp_pkg::MAX_ELAPSED_MS;
        end
        else
        begin
            elapsed_calc = elapsed_diff[vftbp_pkg::ELAPSED_W-1:0];
        end
    end

    // Stage 3: the two partial products of rate * elapsed.
    // Stage 4: refill = q * elapsed + floor(r * elapsed / 1000), which equals
    // floor(rate * elapsed / 1000) exactly.
    assign frac_prod = {{vftbp_pkg::RECIP_W{1'b0}}, s3_pr_reg} *
                       {{vftbp_pkg::PR_W{1'b0}}, vftbp_pkg::RECIP_1000};
    assign refill_calc = vftbp_pkg::REFILL_W'({1'b0, s3_pq_reg}) +
                         vftbp_pkg::REFILL_W'(frac_prod[vftbp_pkg::PR_W+vftbp_pkg::RECIP_W-1:
                                                        vftbp_pkg::RECIP_SHIFT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_item_reg    <= s1_item_reg;
            s2_elapsed_reg <= elapsed_calc;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_item_reg <= s2_item_reg;
            s3_pq_reg   <= {{vftbp_pkg::ELAPSED_W{1'b0}}, rate_q_reg} *
                           {{vftbp_pkg::Q_W{1'b0}}, s2_elapsed_reg};
            s3_pr_reg   <= vftbp_pkg::PR_W'({{vftbp_pkg::ELAPSED_W{1'b0}}, rate_r_reg} *
                                            {{vftbp_pkg::R_W{1'b0}}, s2_elapsed_reg});
        end
        if (s4_free && s3_valid_reg)
        begin
            s4_item_reg   <= s3_item_reg;
            s4_refill_reg <= refill_calc;
        end
    end

    // ------------------------------------------------------------------
    // Balance update. The first paced frame loads the initial fill; later
    // frames add the refill and cap at the bucket. A non-keyframe deep in
    // debt is dropped and may raise an adapt request; any other frame
    // spends its size, saturating at the bottom of the 32-bit range.
    // With pacing off the frame passes and the balance is only reported.
    // ------------------------------------------------------------------
    assign debt_floor = -$signed(vftbp_pkg::DEBT_LIMIT_BYTES);

    always_comb
    begin
        fill_sum    = {{2{tok_reg[vftbp_pkg::TOK_W-1]}}, tok_reg} +
                      $signed(vftbp_pkg::SUM_W'(s4_refill_reg));
        fill_capped = (fill_sum > $signed(vftbp_pkg::SUM_W'(bucket_reg))) ?
                      $signed(vftbp_pkg::SUM_W'(bucket_reg)) : fill_sum;
        if (s4_item_reg.first)
        begin
            tok_filled = $signed(vftbp_pkg::TOK_W'(base_reg));
        end
        else
        begin
            tok_filled = vftbp_pkg::sat32(fill_capped);
        end

        drop       = !s4_item_reg.key && (tok_filled < debt_floor);
        adapt_diff = {1'b0, s4_item_reg.now} - {1'b0, last_adapt_reg};
        adapt_due  = !adapt_diff[vftbp_pkg::NOW_W] &&
                     (adapt_diff[vftbp_pkg::NOW_W-1:0] > vftbp_pkg::ADAPT_GAP_MS);
        spend_sum  = {{2{tok_filled[vftbp_pkg::TOK_W-1]}}, tok_filled} -
                     $signed(vftbp_pkg::SUM_W'(s4_item_reg.bytes));

        tok_next        = tok_reg;
        last_adapt_next = last_adapt_reg;
        forward_next    = 1'b1;
        adapt_next      = 1'b0;
        if (s4_item_reg.pacing)
        begin
            if (drop)
            begin
                tok_next     = tok_filled;
                forward_next = 1'b0;
                if (adapt_due)
                begin
                    adapt_next      = 1'b1;
                    last_adapt_next = s4_item_reg.now;
                end
            end
            else
            begin
                tok_next = vftbp_pkg::sat32(spend_sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg        <= '0;
            last_adapt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= s4_valid_reg;
            end
            if (loop_fire)
            begin
                tok_reg        <= tok_next;
                last_adapt_reg <= last_adapt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (loop_fire)
        begin
            forward_reg     <= forward_next;
            adapt_reg       <= adapt_next;
            token_level_reg <= tok_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign forward       = forward_reg;
    assign adapt_request = adapt_reg;
    assign token_level   = token_level_reg;

`ifndef SYNTHESIS
    // An adapt request only ever comes with a dropped frame.
    a_adapt_only_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && adapt_request |-> !forward)
        else $error("adapt request raised on a forwarded frame");

    // A frame that passes with pacing off leaves the balance and adapt time alone.
    a_bypass_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        loop_fire && !s4_item_reg.pacing |=> $stable(tok_reg) && $stable(last_adapt_reg))
        else $error("state changed by a frame passed with pacing off");

    // The clamped elapsed time never exceeds one second.
    a_elapsed_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> s2_elapsed_reg <= vftbp_pkg::MAX_ELAPSED_MS)
        else $error("elapsed time outside its clamp");

    // Once primed, the bucket stays primed until reset.
    a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(primed_reg))
        else $error("bucket lost its primed mark");
`endif

endmodule
